/* rtl/tqla_pkg.sv */
// shared types and constants for the tabular q-learning agent
package tqla_pkg;

    // default sizes of the state grid and the value word
    localparam int X_BINS_DEF  = 8;
    localparam int Y_BINS_DEF  = 32;
    localparam int Q_WIDTH_DEF = 32;
    localparam int NUM_ACTIONS = 2;

    // field widths
    localparam int OFFSET_W   = 11;
    localparam int CFG_DATA_W = 16;
    localparam int BIN_SIZE_W = 10;
    localparam int CFG_IDX_W  = 3;

    // bin divider: dividend is 12 bits wide, enough for a folded vertical offset
    localparam int DIV_W     = 12;
    localparam int DIV_CNT_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEATH_REWARD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STANDARD_REWARD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT_FACTOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_BIN_SIZE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_BIN_SIZE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd6;

    // configuration reset values
    localparam logic signed [CFG_DATA_W-1:0] DEATH_REWARD_RST    = -16'sd1000;
    localparam logic signed [CFG_DATA_W-1:0] STANDARD_REWARD_RST = 16'sd15;
    localparam logic [CFG_DATA_W-1:0]        LEARNING_RATE_RST   = 16'd39322;
    localparam logic [CFG_DATA_W-1:0]        DISCOUNT_FACTOR_RST = 16'd39322;
    localparam logic [BIN_SIZE_W-1:0]        X_BIN_SIZE_RST      = 10'd40;
    localparam logic [BIN_SIZE_W-1:0]        Y_BIN_SIZE_RST      = 10'd40;
    localparam logic [BIN_SIZE_W-1:0]        FRAME_HEIGHT_RST    = 10'd512;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CELL,
        ST_READ,
        ST_MAX,
        ST_TGT,
        ST_LR,
        ST_WR,
        ST_PICK,
        ST_DONE
    } tqla_state_t;

endpackage

/* rtl/tabular_q_learning_agent.sv */
// tabular q-learning agent: binning divider, q table memory and update sequencer
//
//   channel   ports                                   direction
//   s_        s_valid s_ready s_offset_x s_offset_y   observation request in
//             s_died
//   m_        m_valid m_ready m_chosen_action         action result out
//             m_bin_clamped
//   cfg_      cfg_we cfg_index cfg_data               register write, no wait
//
// One request at a time. Each request runs through the bit-serial bin
// divider and the table read; when the held cell is updated it also makes
// two passes through the shared multiplier and the write back.
// After reset a clearing pass writes zero rows to all X_BINS*Y_BINS cells,
// one row a cycle, with s_ready low. A result may wait on m_ready while the
// next request is already accepted; a stalled result holds only the last state.
module tabular_q_learning_agent #(
    parameter int X_BINS  = tqla_pkg::X_BINS_DEF,
    parameter int Y_BINS  = tqla_pkg::Y_BINS_DEF,
    parameter int Q_WIDTH = tqla_pkg::Q_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // observation channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [tqla_pkg::OFFSET_W-1:0]   s_offset_x,
    input  logic signed [tqla_pkg::OFFSET_W-1:0]   s_offset_y,
    input  logic                                   s_died,
    // result channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_chosen_action,
    output logic                                   m_bin_clamped,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [tqla_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tqla_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int NCELLS = X_BINS * Y_BINS;
    localparam int CW     = $clog2(NCELLS);
    localparam int RW     = tqla_pkg::NUM_ACTIONS * Q_WIDTH;
    // difference width: reward term and value term plus headroom
    localparam int DW     = ((Q_WIDTH > 32) ? Q_WIDTH : 32) + 2;
    localparam int SW     = DW + 1;
    localparam int PW     = DW + tqla_pkg::CFG_DATA_W + 1;
    localparam int DVW    = tqla_pkg::DIV_W;
    localparam int BW     = tqla_pkg::BIN_SIZE_W;

    localparam logic signed [SW-1:0] QMAX = (SW'(1) <<< (Q_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] QMIN = -QMAX - SW'(1);

    localparam logic [CW-1:0]  LAST_CELL = CW'(NCELLS - 1);
    localparam logic [CW-1:0]  X_LAST    = CW'(X_BINS - 1);
    localparam logic [CW-1:0]  Y_LAST    = CW'(Y_BINS - 1);
    localparam logic [CW-1:0]  Y_STRIDE  = CW'(Y_BINS);
    localparam logic [DVW-1:0] X_LIMIT   = DVW'(X_BINS);
    localparam logic [DVW-1:0] Y_LIMIT   = DVW'(Y_BINS - 1);
    localparam logic [tqla_pkg::DIV_CNT_W-1:0] DIV_LAST =
        tqla_pkg::DIV_CNT_W'(DVW - 1);

    // control state
    tqla_pkg::tqla_state_t state_reg, state_next;
    logic [CW-1:0]                    clr_cnt_reg, clr_cnt_next;
    logic [tqla_pkg::DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                             held_valid_reg, held_valid_next;
    logic [CW-1:0]                    held_cell_reg, held_cell_next;
    logic                             held_action_reg, held_action_next;
    logic                             m_valid_reg, m_valid_next;

    // configuration registers
    logic signed [tqla_pkg::CFG_DATA_W-1:0] death_rew_reg, std_rew_reg;
    logic [tqla_pkg::CFG_DATA_W-1:0]        lr_reg, df_reg;
    logic [BW-1:0]                          xbs_reg, ybs_reg, fh_reg;

    // datapath registers
    logic [DVW-1:0]           dvd_x_reg, dvd_x_next, dvd_y_reg, dvd_y_next;
    logic [BW-1:0]            rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [BW-1:0]            dsr_x_reg, dsr_x_next, dsr_y_reg, dsr_y_next;
    logic                     x_neg_reg, x_neg_next;
    logic                     died_reg, died_next;
    logic [CW-1:0]            cell_reg, cell_next;
    logic                     clamp_reg, clamp_next;
    logic signed [PW-1:0]     prod_reg;
    logic signed [DW-1:0]     diff_reg, diff_next;
    logic [RW-1:0]            upd_row_reg, upd_row_next;
    logic [RW-1:0]            held_row_reg, held_row_next;
    logic                     res_action_reg, res_action_next;
    logic                     m_action_reg, m_action_next;
    logic                     m_clamped_reg, m_clamped_next;
    logic [RW-1:0]            rd_row_reg;

    // table memory
    logic [RW-1:0]            q_mem [NCELLS];
    logic                     mem_we;
    logic [CW-1:0]            mem_waddr;
    logic [RW-1:0]            mem_wdata;
    logic                     mem_re;

    // combinational helpers
    logic signed [DVW-1:0]    oy_ext;
    logic [BW:0]              rs_x, rs_y;
    logic                     ge_x, ge_y;
    logic [CW-1:0]            xb, yb;
    logic                     xc, yc;
    logic signed [Q_WIDTH-1:0] n0, n1, mx, q_held, p0, p1;
    logic [RW-1:0]            pick_row;
    logic signed [DW-1:0]     mul_a;
    logic [tqla_pkg::CFG_DATA_W-1:0] mul_b;
    logic signed [PW-1:0]     mul_a_ext, mul_b_ext;
    logic signed [DW-1:0]     target;
    logic signed [SW-1:0]     sum;
    logic signed [Q_WIDTH-1:0] new_q;

    assign s_ready         = (state_reg == tqla_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_chosen_action = m_action_reg;
    assign m_bin_clamped   = m_clamped_reg;

    // divider step for both bins
    assign rs_x = {rem_x_reg, dvd_x_reg[DVW-1]};
    assign rs_y = {rem_y_reg, dvd_y_reg[DVW-1]};
    assign ge_x = (rs_x >= {1'b0, dsr_x_reg});
    assign ge_y = (rs_y >= {1'b0, dsr_y_reg});

    // vertical offset sign extended for folding
    assign oy_ext = DVW'(s_offset_y);

    // clamp quotients into the grid; a negative horizontal offset always clamps low
    always_comb begin
        if (x_neg_reg || (dvd_x_reg == '0)) begin
            xb = '0;
            xc = 1'b1;
        end else if (dvd_x_reg > X_LIMIT) begin
            xb = X_LAST;
            xc = 1'b1;
        end else begin
            xb = CW'(dvd_x_reg - DVW'(1));
            xc = 1'b0;
        end
        if (dvd_y_reg > Y_LIMIT) begin
            yb = Y_LAST;
            yc = 1'b1;
        end else begin
            yb = CW'(dvd_y_reg);
            yc = 1'b0;
        end
    end

    // values of the new cell and of the held entry
    assign n0     = rd_row_reg[Q_WIDTH-1:0];
    assign n1     = rd_row_reg[RW-1:Q_WIDTH];
    assign mx     = (n1 > n0) ? n1 : n0;
    assign q_held = held_action_reg ? held_row_reg[RW-1:Q_WIDTH]
                                    : held_row_reg[Q_WIDTH-1:0];

    // shared multiplier, value times unsigned q0.16 factor
    always_comb begin
        if (state_reg == tqla_pkg::ST_LR) begin
            mul_a = diff_reg;
            mul_b = lr_reg;
        end else begin
            mul_a = DW'(mx);
            mul_b = df_reg;
        end
    end
    assign mul_a_ext = PW'(mul_a);
    assign mul_b_ext = $signed(PW'(mul_b));

    // target and saturated new value
    assign target = (DW'(death_rew_reg) <<< 16) & {DW{died_reg}}
                  | (DW'(std_rew_reg) <<< 16) & {DW{!died_reg}};
    assign sum    = SW'(q_held) + SW'(prod_reg >>> 16);
    always_comb begin
        if (sum > QMAX) begin
            new_q = Q_WIDTH'(QMAX);
        end else if (sum < QMIN) begin
            new_q = Q_WIDTH'(QMIN);
        end else begin
            new_q = Q_WIDTH'(sum);
        end
    end

    // row of the new cell after the update
    assign pick_row = (held_valid_reg && (cell_reg == held_cell_reg)) ? upd_row_reg
                                                                       : rd_row_reg;
    assign p0 = pick_row[Q_WIDTH-1:0];
    assign p1 = pick_row[RW-1:Q_WIDTH];

    // sequencer: next state, datapath next values and memory controls
    always_comb begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        div_cnt_next     = div_cnt_reg;
        held_valid_next  = held_valid_reg;
        held_cell_next   = held_cell_reg;
        held_action_next = held_action_reg;
        held_row_next    = held_row_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_action_next    = m_action_reg;
        m_clamped_next   = m_clamped_reg;
        dvd_x_next       = dvd_x_reg;
        dvd_y_next       = dvd_y_reg;
        rem_x_next       = rem_x_reg;
        rem_y_next       = rem_y_reg;
        dsr_x_next       = dsr_x_reg;
        dsr_y_next       = dsr_y_reg;
        x_neg_next       = x_neg_reg;
        died_next        = died_reg;
        cell_next        = cell_reg;
        clamp_next       = clamp_reg;
        diff_next        = diff_reg;
        upd_row_next     = upd_row_reg;
        res_action_next  = res_action_reg;
        mem_we           = 1'b0;
        mem_waddr        = held_cell_reg;
        mem_wdata        = upd_row_next;
        mem_re           = 1'b0;

        unique case (state_reg)
            tqla_pkg::ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == LAST_CELL) begin
                    state_next = tqla_pkg::ST_IDLE;
                end
            end
            tqla_pkg::ST_IDLE: begin
                if (s_valid) begin
                    x_neg_next   = s_offset_x[tqla_pkg::OFFSET_W-1];
                    dvd_x_next   = s_offset_x[tqla_pkg::OFFSET_W-1] ? '0
                                                                    : DVW'(s_offset_x);
                    dvd_y_next   = s_offset_y[tqla_pkg::OFFSET_W-1]
                                   ? DVW'(-oy_ext) + DVW'(fh_reg)
                                   : DVW'(s_offset_y);
                    dsr_x_next   = (xbs_reg == '0) ? BW'(1) : xbs_reg;
                    dsr_y_next   = (ybs_reg == '0) ? BW'(1) : ybs_reg;
                    rem_x_next   = '0;
                    rem_y_next   = '0;
                    died_next    = s_died;
                    div_cnt_next = '0;
                    state_next   = tqla_pkg::ST_DIV;
                end
            end
            tqla_pkg::ST_DIV: begin
                // restoring division, one quotient bit per cycle
                rem_x_next   = ge_x ? BW'(rs_x - {1'b0, dsr_x_reg}) : rs_x[BW-1:0];
                rem_y_next   = ge_y ? BW'(rs_y - {1'b0, dsr_y_reg}) : rs_y[BW-1:0];
                dvd_x_next   = {dvd_x_reg[DVW-2:0], ge_x};
                dvd_y_next   = {dvd_y_reg[DVW-2:0], ge_y};
                div_cnt_next = div_cnt_reg + tqla_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = tqla_pkg::ST_CELL;
                end
            end
            tqla_pkg::ST_CELL: begin
                cell_next  = CW'(xb * Y_STRIDE) + yb;
                clamp_next = xc || yc;
                state_next = tqla_pkg::ST_READ;
            end
            tqla_pkg::ST_READ: begin
                mem_re     = 1'b1;
                state_next = tqla_pkg::ST_MAX;
            end
            tqla_pkg::ST_MAX: begin
                // multiplier takes max q of the new cell times the discount
                state_next = held_valid_reg ? tqla_pkg::ST_TGT : tqla_pkg::ST_PICK;
            end
            tqla_pkg::ST_TGT: begin
                diff_next  = target + DW'(prod_reg >>> 16) - DW'(q_held);
                state_next = tqla_pkg::ST_LR;
            end
            tqla_pkg::ST_LR: begin
                // multiplier takes the difference times the learning rate
                state_next = tqla_pkg::ST_WR;
            end
            tqla_pkg::ST_WR: begin
                upd_row_next = held_action_reg ? {new_q, held_row_reg[Q_WIDTH-1:0]}
                                               : {held_row_reg[RW-1:Q_WIDTH], new_q};
                mem_we       = 1'b1;
                mem_waddr    = held_cell_reg;
                mem_wdata    = upd_row_next;
                state_next   = tqla_pkg::ST_PICK;
            end
            tqla_pkg::ST_PICK: begin
                res_action_next  = (p1 > p0);
                held_action_next = (p1 > p0);
                held_cell_next   = cell_reg;
                held_row_next    = pick_row;
                held_valid_next  = !died_reg;
                state_next       = tqla_pkg::ST_DONE;
            end
            tqla_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_action_next  = res_action_reg;
                    m_clamped_next = clamp_reg;
                    state_next     = tqla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tqla_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tqla_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg     <= '0;
            div_cnt_reg     <= '0;
            held_valid_reg  <= 1'b0;
            held_cell_reg   <= '0;
            held_action_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            clr_cnt_reg     <= clr_cnt_next;
            div_cnt_reg     <= div_cnt_next;
            held_valid_reg  <= held_valid_next;
            held_cell_reg   <= held_cell_next;
            held_action_reg <= held_action_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            death_rew_reg <= tqla_pkg::DEATH_REWARD_RST;
            std_rew_reg   <= tqla_pkg::STANDARD_REWARD_RST;
            lr_reg        <= tqla_pkg::LEARNING_RATE_RST;
            df_reg        <= tqla_pkg::DISCOUNT_FACTOR_RST;
            xbs_reg       <= tqla_pkg::X_BIN_SIZE_RST;
            ybs_reg       <= tqla_pkg::Y_BIN_SIZE_RST;
            fh_reg        <= tqla_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                tqla_pkg::REG_DEATH_REWARD:    death_rew_reg <= $signed(cfg_data);
                tqla_pkg::REG_STANDARD_REWARD: std_rew_reg   <= $signed(cfg_data);
                tqla_pkg::REG_LEARNING_RATE:   lr_reg        <= cfg_data;
                tqla_pkg::REG_DISCOUNT_FACTOR: df_reg        <= cfg_data;
                tqla_pkg::REG_X_BIN_SIZE:      xbs_reg       <= cfg_data[BW-1:0];
                tqla_pkg::REG_Y_BIN_SIZE:      ybs_reg       <= cfg_data[BW-1:0];
                tqla_pkg::REG_FRAME_HEIGHT:    fh_reg        <= cfg_data[BW-1:0];
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        dvd_x_reg      <= dvd_x_next;
        dvd_y_reg      <= dvd_y_next;
        rem_x_reg      <= rem_x_next;
        rem_y_reg      <= rem_y_next;
        dsr_x_reg      <= dsr_x_next;
        dsr_y_reg      <= dsr_y_next;
        x_neg_reg      <= x_neg_next;
        died_reg       <= died_next;
        cell_reg       <= cell_next;
        clamp_reg      <= clamp_next;
        prod_reg       <= mul_a_ext * mul_b_ext;
        diff_reg       <= diff_next;
        upd_row_reg    <= upd_row_next;
        held_row_reg   <= held_row_next;
        res_action_reg <= res_action_next;
        m_action_reg   <= m_action_next;
        m_clamped_reg  <= m_clamped_next;
    end

    // q table: one row of both action values per cell, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            q_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_row_reg <= q_mem[cell_reg];
        end
    end

`ifndef SYNTHESIS
    // the table is written back only for a held cell or by the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && (state_reg != tqla_pkg::ST_CLEAR)) |-> held_valid_reg)
        else $error("q table written without a held cell");

    // a death leaves no held cell for the next request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tqla_pkg::ST_PICK) |=> (held_valid_reg == !$past(died_reg)))
        else $error("held cell flag does not follow the death flag");

    // a new result only comes out of the final state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && m_valid_next) |-> (state_reg == tqla_pkg::ST_DONE))
        else $error("result produced outside the final state");

    // no result is pending while the table is still being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tqla_pkg::ST_CLEAR) |-> (!m_valid_reg && !s_ready))
        else $error("handshake active during clearing pass");
`endif

endmodule

/* tb/sv/tabular_q_learning_agent_test.sv */
// self-checking testbench for the tabular q-learning agent
module tabular_q_learning_agent_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD    = 4;
    localparam int     X_BINS        = tqla_pkg::X_BINS_DEF;
    localparam int     Y_BINS        = tqla_pkg::Y_BINS_DEF;
    localparam int     Q_WIDTH       = tqla_pkg::Q_WIDTH_DEF;
    localparam int     CELLS         = X_BINS * Y_BINS;
    localparam longint Q_MAX         = (longint'(1) <<< (Q_WIDTH - 1)) - 1;
    localparam longint Q_MIN         = -Q_MAX - 1;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     DRAIN_CYCLES  = 40;
    localparam int     CYCLE_LIMIT   = 400_000;
    localparam int     MAX_REPORTS   = 10;

    // index past the last register, writes to it must be dropped
    localparam logic [tqla_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum {RATES_RANDOM, RATES_ZERO, RATES_FULL} rate_mode_t;

    typedef struct packed {
        logic chosen_action;
        logic bin_clamped;
    } action_result_t;

    logic                                   aclk            = 1'b0;
    logic                                   aresetn         = 1'b0;
    logic                                   s_valid         = 1'b0;
    logic                                   s_ready;
    logic signed [tqla_pkg::OFFSET_W-1:0]   s_offset_x      = '0;
    logic signed [tqla_pkg::OFFSET_W-1:0]   s_offset_y      = '0;
    logic                                   s_died          = 1'b0;
    logic                                   m_valid;
    logic                                   m_ready         = 1'b1;
    logic                                   m_chosen_action;
    logic                                   m_bin_clamped;
    logic                                   cfg_we          = 1'b0;
    logic [tqla_pkg::CFG_IDX_W-1:0]         cfg_index       = '0;
    logic [tqla_pkg::CFG_DATA_W-1:0]        cfg_data        = '0;

    // predicted agent state and settings
    logic signed [Q_WIDTH-1:0]              q_table [CELLS*tqla_pkg::NUM_ACTIONS];
    int                                     held_cell;
    logic                                   held_action;
    logic                                   held_valid;
    logic signed [tqla_pkg::CFG_DATA_W-1:0] death_reward_cfg;
    logic signed [tqla_pkg::CFG_DATA_W-1:0] standard_reward_cfg;
    logic [tqla_pkg::CFG_DATA_W-1:0]        rate_cfg;
    logic [tqla_pkg::CFG_DATA_W-1:0]        discount_cfg;
    logic [tqla_pkg::BIN_SIZE_W-1:0]        x_bin_cfg;
    logic [tqla_pkg::BIN_SIZE_W-1:0]        y_bin_cfg;
    logic [tqla_pkg::BIN_SIZE_W-1:0]        frame_cfg;

    action_result_t                         pending_actions [$];
    int                                     mismatch_count  = 0;
    int                                     result_count    = 0;
    int                                     cycle_count     = 0;
    int                                     ready_hold      = 0;
    bit                                     idle_on         = 1'b1;

    tabular_q_learning_agent u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_offset_x      (s_offset_x),
        .s_offset_y      (s_offset_y),
        .s_died          (s_died),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chosen_action (m_chosen_action),
        .m_bin_clamped   (m_bin_clamped),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side back-pressure in short random bursts
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (idle_on && aresetn && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each delivered action against the oldest prediction
    always @(posedge aclk) begin
        action_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_actions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result %0d with no request pending: action %0b clamped %0b",
                             result_count, m_chosen_action, m_bin_clamped);
            end else begin
                want = pending_actions.pop_front();
                if (m_chosen_action !== want.chosen_action ||
                    m_bin_clamped !== want.bin_clamped) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result %0d: action exp %0b got %0b, clamped exp %0b got %0b",
                                 result_count, want.chosen_action, m_chosen_action,
                                 want.bin_clamped, m_bin_clamped);
                end
            end
            result_count++;
        end
    end

    // predictor back to reset contents
    function automatic void reset_predictor();
        foreach (q_table[i])
            q_table[i] = '0;
        held_cell           = 0;
        held_action         = 1'b0;
        held_valid          = 1'b0;
        death_reward_cfg    = tqla_pkg::DEATH_REWARD_RST;
        standard_reward_cfg = tqla_pkg::STANDARD_REWARD_RST;
        rate_cfg            = tqla_pkg::LEARNING_RATE_RST;
        discount_cfg        = tqla_pkg::DISCOUNT_FACTOR_RST;
        x_bin_cfg           = tqla_pkg::X_BIN_SIZE_RST;
        y_bin_cfg           = tqla_pkg::Y_BIN_SIZE_RST;
        frame_cfg           = tqla_pkg::FRAME_HEIGHT_RST;
    endfunction

    // bin the observation, update the held entry, pick the greedy action
    function automatic action_result_t predict_action(
        input logic signed [tqla_pkg::OFFSET_W-1:0] ox,
        input logic signed [tqla_pkg::OFFSET_W-1:0] oy,
        input logic                                 died
    );
        action_result_t res;
        int     x_div, y_div, frame_i, x_off, y_off, x_bin, y_bin, cell_idx, row;
        longint n0, n1, best, reward, target, q_old, q_new;
        x_div   = (x_bin_cfg == '0) ? 1 : int'(x_bin_cfg);
        y_div   = (y_bin_cfg == '0) ? 1 : int'(y_bin_cfg);
        frame_i = int'(frame_cfg);
        x_off   = int'(ox);
        y_off   = int'(oy);
        res.bin_clamped = 1'b0;

        // negative vertical offset folds to magnitude plus frame height
        if (y_off < 0)
            y_off = frame_i - y_off;
        x_bin = x_off / x_div - 1;
        y_bin = y_off / y_div;
        if (x_bin < 0) begin
            x_bin = 0;
            res.bin_clamped = 1'b1;
        end
        if (x_bin > X_BINS - 1) begin
            x_bin = X_BINS - 1;
            res.bin_clamped = 1'b1;
        end
        if (y_bin > Y_BINS - 1) begin
            y_bin = Y_BINS - 1;
            res.bin_clamped = 1'b1;
        end
        cell_idx = x_bin * Y_BINS + y_bin;

        // learning step on the held cell and action
        if (held_valid) begin
            n0     = longint'(q_table[cell_idx * tqla_pkg::NUM_ACTIONS]);
            n1     = longint'(q_table[cell_idx * tqla_pkg::NUM_ACTIONS + 1]);
            best   = (n1 > n0) ? n1 : n0;
            reward = died ? longint'(death_reward_cfg) : longint'(standard_reward_cfg);
            target = reward * 65536 + ((best * longint'(discount_cfg)) >>> 16);
            row    = held_cell * tqla_pkg::NUM_ACTIONS + int'(held_action);
            q_old  = longint'(q_table[row]);
            q_new  = q_old + (((target - q_old) * longint'(rate_cfg)) >>> 16);
            if (q_new > Q_MAX)
                q_new = Q_MAX;
            else if (q_new < Q_MIN)
                q_new = Q_MIN;
            q_table[row] = q_new[Q_WIDTH-1:0];
        end

        // greedy pick from the updated table
        n0 = longint'(q_table[cell_idx * tqla_pkg::NUM_ACTIONS]);
        n1 = longint'(q_table[cell_idx * tqla_pkg::NUM_ACTIONS + 1]);
        res.chosen_action = (n1 > n0);
        held_cell   = cell_idx;
        held_action = res.chosen_action;
        held_valid  = !died;
        return res;
    endfunction

    // one register write, write enable left high for back-to-back writes
    task automatic write_reg(input logic [tqla_pkg::CFG_IDX_W-1:0] index,
                             input logic [tqla_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        case (index)
            tqla_pkg::REG_DEATH_REWARD:    death_reward_cfg    = data;
            tqla_pkg::REG_STANDARD_REWARD: standard_reward_cfg = data;
            tqla_pkg::REG_LEARNING_RATE:   rate_cfg            = data;
            tqla_pkg::REG_DISCOUNT_FACTOR: discount_cfg        = data;
            tqla_pkg::REG_X_BIN_SIZE:      x_bin_cfg = data[tqla_pkg::BIN_SIZE_W-1:0];
            tqla_pkg::REG_Y_BIN_SIZE:      y_bin_cfg = data[tqla_pkg::BIN_SIZE_W-1:0];
            tqla_pkg::REG_FRAME_HEIGHT:    frame_cfg = data[tqla_pkg::BIN_SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int death_rwd,
                                  input int std_rwd,
                                  input int rate,
                                  input int discount,
                                  input int x_size,
                                  input int y_size,
                                  input int frame);
        write_reg(tqla_pkg::REG_DEATH_REWARD, tqla_pkg::CFG_DATA_W'(death_rwd));
        write_reg(tqla_pkg::REG_STANDARD_REWARD, tqla_pkg::CFG_DATA_W'(std_rwd));
        write_reg(tqla_pkg::REG_LEARNING_RATE, tqla_pkg::CFG_DATA_W'(rate));
        write_reg(tqla_pkg::REG_DISCOUNT_FACTOR, tqla_pkg::CFG_DATA_W'(discount));
        write_reg(tqla_pkg::REG_X_BIN_SIZE, tqla_pkg::CFG_DATA_W'(x_size));
        write_reg(tqla_pkg::REG_Y_BIN_SIZE, tqla_pkg::CFG_DATA_W'(y_size));
        write_reg(tqla_pkg::REG_FRAME_HEIGHT, tqla_pkg::CFG_DATA_W'(frame));
        cfg_we <= 1'b0;
    endtask

    // wait until every predicted action has come back and the block is idle
    task automatic settle_block();
        s_valid <= 1'b0;
        while (pending_actions.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // send one observation request, record its prediction once accepted
    task automatic send_observation(input int   ox,
                                    input int   oy,
                                    input logic died);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_offset_x <= tqla_pkg::OFFSET_W'(ox);
        s_offset_y <= tqla_pkg::OFFSET_W'(oy);
        s_died     <= died;
        do @(posedge aclk); while (!s_ready);
        pending_actions.push_back(predict_action(tqla_pkg::OFFSET_W'(ox),
                                                 tqla_pkg::OFFSET_W'(oy), died));
    endtask

    // episodes of drifting offsets ending in a death, with some noise requests
    task automatic run_episodes(input int item_total, input bit quiet_run);
        int sent, ep_len, k, step, drift;
        int x_div, y_div, x_span, y_span, ox_run, oy_run;
        sent   = 0;
        x_div  = (x_bin_cfg == '0) ? 1 : int'(x_bin_cfg);
        y_div  = (y_bin_cfg == '0) ? 1 : int'(y_bin_cfg);
        x_span = (x_div * (X_BINS + 1) > 1023) ? 1023 : x_div * (X_BINS + 1);
        y_span = (y_div * Y_BINS > 1023) ? 1023 : y_div * Y_BINS;
        while (sent < item_total) begin
            ep_len  = $urandom_range(3, 40);
            idle_on = !quiet_run && ($urandom_range(0, 3) != 0);
            ox_run  = $urandom_range(0, x_span);
            oy_run  = int'($urandom_range(0, y_span)) - y_span / 4;
            for (k = 0; k < ep_len && sent < item_total; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_observation($urandom, $urandom, 1'($urandom_range(0, 1)));
                end else begin
                    step   = $urandom_range(0, x_div);
                    ox_run = ox_run - step;
                    if (ox_run < -x_div)
                        ox_run = x_span;
                    drift  = $urandom_range(0, 2 * y_div);
                    oy_run = oy_run + drift - y_div;
                    if (oy_run > 1023)
                        oy_run = 1023;
                    if (oy_run < -1024)
                        oy_run = -1024;
                    send_observation(ox_run, oy_run, k == ep_len - 1);
                end
                sent++;
            end
        end
    endtask

    // field extremes, folding, clamping and death under reset settings
    task automatic test_reset_defaults();
        settle_block();
        send_observation(0, 0, 1'b0);
        send_observation(1023, 1023, 1'b0);
        send_observation(-1024, -1024, 1'b0);
        send_observation(80, 100, 1'b0);
        send_observation(80, 100, 1'b0);
        send_observation(80, -5, 1'b0);
        send_observation(120, 40, 1'b1);
        send_observation(120, 40, 1'b0);
        send_observation(-1, -1, 1'b0);
        send_observation(40, 0, 1'b0);
        send_observation(1023, -1024, 1'b1);
    endtask

    // full rates and extreme rewards drive the value into both saturation limits
    task automatic test_extreme_settings();
        int n;
        settle_block();
        apply_settings('h8000, 'h7fff, 'hffff, 'hffff, 1, 1, 1023);
        for (n = 0; n < 5; n++)
            send_observation(5, 3, 1'b0);
        settle_block();
        write_reg(tqla_pkg::REG_STANDARD_REWARD, 16'h8000);
        cfg_we <= 1'b0;
        for (n = 0; n < 7; n++)
            send_observation(5, 3, 1'b0);
    endtask

    // zero bin sizes act as one, unused index ignored, widest bins with shortest frame
    task automatic test_bin_size_corners();
        settle_block();
        write_reg(tqla_pkg::REG_X_BIN_SIZE, '0);
        write_reg(tqla_pkg::REG_Y_BIN_SIZE, '0);
        write_reg(REG_UNUSED, 16'h0003);
        cfg_we <= 1'b0;
        send_observation(3, 2, 1'b0);
        send_observation(-7, -3, 1'b0);
        settle_block();
        apply_settings(int'(tqla_pkg::DEATH_REWARD_RST), int'(tqla_pkg::STANDARD_REWARD_RST),
                       int'(tqla_pkg::LEARNING_RATE_RST), int'(tqla_pkg::DISCOUNT_FACTOR_RST),
                       1023, 1023, 1);
        send_observation(1023, 1023, 1'b0);
        send_observation(-1024, -1024, 1'b0);
        send_observation(1022, -1022, 1'b1);
    endtask

    // random settings and random episodes
    task automatic test_random_episodes(input rate_mode_t mode, input int item_total);
        int rate, discount, x_size, y_size;
        settle_block();
        case (mode)
            RATES_ZERO: begin
                rate     = 0;
                discount = 0;
            end
            RATES_FULL: begin
                rate     = 'hffff;
                discount = 'hffff;
            end
            default: begin
                rate     = $urandom;
                discount = $urandom;
            end
        endcase
        x_size = ($urandom_range(0, 3) != 0) ? $urandom_range(4, 130) : $urandom_range(1, 1023);
        y_size = ($urandom_range(0, 3) != 0) ? $urandom_range(2, 64) : $urandom_range(1, 1023);
        apply_settings($urandom, $urandom, rate, discount, x_size, y_size,
                       $urandom_range(1, 1023));
        run_episodes(item_total, 1'b0);
    endtask

    // closing stretch with no idling on either side
    task automatic test_steady_stream(input int item_total);
        settle_block();
        apply_settings($urandom, $urandom, $urandom, $urandom, $urandom_range(8, 100),
                       $urandom_range(4, 48), $urandom_range(1, 1023));
        run_episodes(item_total, 1'b1);
    endtask

    initial begin
        reset_predictor();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_extreme_settings();
        test_bin_size_corners();
        test_random_episodes(RATES_RANDOM, 400);
        test_random_episodes(RATES_ZERO, 250);
        test_random_episodes(RATES_FULL, 300);
        test_random_episodes(RATES_RANDOM, 400);
        test_steady_stream(300);

        // drain outstanding results
        s_valid <= 1'b0;
        while (pending_actions.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/tqla_pkg.sv
rtl/tabular_q_learning_agent.sv
tb/sv/tabular_q_learning_agent_test.sv
